FILE: rtl/mvr_pkg.sv
// Shared constants, types and register codes for motion vector reconstruction.
package mvr_pkg;

   localparam int NUM_PRED    = 8;
   localparam int PRED_IDX_W  = 3;
   localparam int PRED_W      = 14;
   localparam int MV_W        = 13;
   localparam int DELTA_W     = 15;
   localparam int SUM_W       = 16;
   localparam int FCODE_W     = 4;
   localparam int NUM_FCODE   = 4;
   localparam int RSIZE_W     = 4;
   localparam int CODE_W      = 6;
   localparam int RESID_W     = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 4;
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 16;

   localparam logic [FCODE_W-1:0] FCODE_MIN = 4'd1;
   localparam logic [FCODE_W-1:0] FCODE_MAX = 4'd9;
   localparam logic [RSIZE_W-1:0] WRAP_BASE = 4'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FCODE_FWD_HORIZ = 3'd0,
      CSR_FCODE_FWD_VERT  = 3'd1,
      CSR_FCODE_BWD_HORIZ = 3'd2,
      CSR_FCODE_BWD_VERT  = 3'd3,
      CSR_FRAME_PICTURE   = 3'd4
   } csr_index_type;

   typedef enum logic {
      ACT_RECON = 1'b0,
      ACT_CLEAR = 1'b1
   } action_type;

   typedef struct packed {
      logic [NUM_FCODE-1:0][FCODE_W-1:0] fcode;
      logic                              frame_picture;
   } cfg_type;

   typedef struct packed {
      logic                        clear;
      logic [PRED_IDX_W-1:0]       idx;
      logic                        field_case;
      logic [RSIZE_W-1:0]          rsize;
      logic signed [DELTA_W-1:0]   delta;
   } entry_type;

endpackage

FILE: rtl/motion_vector_reconstruct.sv
// Top level of the motion vector reconstruction block.
// Takes one request per clock cycle while the queue is not full, and returns one
// result per request in order; a request goes into a queue slot and, once the back
// stage pops it, its result is held in the result register. The rate is set by the
// back stage, which reads a predictor, adds the delta, wraps the sum and writes the
// predictor back, so consecutive requests on the same predictor follow each other
// without a bubble. A two-entry queue parts the front stage from the back stage and
// lets further requests be taken while a result waits on rsp_tready, until it fills.
// The configuration port is always ready; the user must write it only while the
// block is idle (not enforced); indexes beyond the register list are ignored.
module motion_vector_reconstruct (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [5:0] mv_code, [13:6] mv_resid, [15:14] zero
   input  logic [mvr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] action, [1] vector_sel, [2] backward, [3] vertical, [4] field_format
   input  logic [mvr_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [12:0] motion_vector, [15:13] zero
   output logic [mvr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mvr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mvr_pkg::CSR_DATA_W-1:0]      csr_data
);

   mvr_pkg::cfg_type                  cfg_ff, cfg_in;
   logic                              q_full;
   logic                              q_push;
   mvr_pkg::entry_type                q_entry;
   logic                              q_pop;
   logic                              head_valid;
   mvr_pkg::entry_type                head_entry;
   logic signed [mvr_pkg::MV_W-1:0]   out_mv;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mvr_pkg::CSR_FCODE_FWD_HORIZ: cfg_in.fcode[0] = csr_data;
            mvr_pkg::CSR_FCODE_FWD_VERT:  cfg_in.fcode[1] = csr_data;
            mvr_pkg::CSR_FCODE_BWD_HORIZ: cfg_in.fcode[2] = csr_data;
            mvr_pkg::CSR_FCODE_BWD_VERT:  cfg_in.fcode[3] = csr_data;
            mvr_pkg::CSR_FRAME_PICTURE:   cfg_in.frame_picture = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mvr_pkg::NUM_FCODE; i++) begin
            cfg_ff.fcode[i] <= mvr_pkg::FCODE_MIN;
         end
         cfg_ff.frame_picture <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mvr_front u_front (
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .action          (req_tuser[0]),
      .vector_sel      (req_tuser[1]),
      .backward        (req_tuser[2]),
      .vertical        (req_tuser[3]),
      .field_format    (req_tuser[4]),
      .mv_code         (req_tdata[5:0]),
      .mv_resid        (req_tdata[13:6]),
      .cfg             (cfg_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   mvr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mvr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_mv     (out_mv)
   );

   assign rsp_tdata = {{(mvr_pkg::RSP_TDATA_W-mvr_pkg::MV_W){1'b0}}, out_mv};

endmodule

FILE: rtl/mvr_front.sv
// Front stage: classify a request and build its motion delta and predictor index.
module mvr_front (
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic                                 action,
   input  logic                                 vector_sel,
   input  logic                                 backward,
   input  logic                                 vertical,
   input  logic                                 field_format,
   input  logic signed [mvr_pkg::CODE_W-1:0]    mv_code,
   input  logic [mvr_pkg::RESID_W-1:0]          mv_resid,
   input  mvr_pkg::cfg_type                     cfg,
   input  logic                                 q_full,
   output logic                                 q_push,
   output mvr_pkg::entry_type                   q_entry
);

   logic [mvr_pkg::FCODE_W-1:0]  fcode_sel;
   logic [mvr_pkg::FCODE_W-1:0]  fcode_clamp;
   logic [mvr_pkg::RSIZE_W-1:0]  rsize;
   logic [mvr_pkg::RESID_W:0]    f_scale;
   logic [mvr_pkg::RESID_W-1:0]  resid_mask;
   logic [mvr_pkg::CODE_W:0]     code_ext;
   logic [mvr_pkg::CODE_W:0]     mag;
   logic [mvr_pkg::CODE_W-1:0]   mag_m1;
   logic [mvr_pkg::PRED_W-1:0]   scaled;
   logic [mvr_pkg::PRED_W-1:0]   mag_delta;
   logic signed [mvr_pkg::DELTA_W-1:0] delta;

   always_comb begin
      fcode_sel = cfg.fcode[{backward, vertical}];
      if (fcode_sel < mvr_pkg::FCODE_MIN) begin
         fcode_clamp = mvr_pkg::FCODE_MIN;
      end else if (fcode_sel > mvr_pkg::FCODE_MAX) begin
         fcode_clamp = mvr_pkg::FCODE_MAX;
      end else begin
         fcode_clamp = fcode_sel;
      end
      rsize      = fcode_clamp - mvr_pkg::FCODE_MIN;
      f_scale    = (mvr_pkg::RESID_W+1)'(1) << rsize;
      resid_mask = mvr_pkg::RESID_W'(f_scale - (mvr_pkg::RESID_W+1)'(1));
      code_ext   = {mv_code[mvr_pkg::CODE_W-1], mv_code};
      mag        = mv_code[mvr_pkg::CODE_W-1] ? (~code_ext + 1'b1) : code_ext;
      mag_m1     = mvr_pkg::CODE_W'(mag - 1'b1);
      scaled     = mvr_pkg::PRED_W'(mag_m1) << rsize;
      mag_delta  = scaled + mvr_pkg::PRED_W'(mv_resid & resid_mask)
                   + mvr_pkg::PRED_W'(1);
      if (rsize == '0 || mv_code == '0) begin
         delta = {{(mvr_pkg::DELTA_W-mvr_pkg::CODE_W){mv_code[mvr_pkg::CODE_W-1]}},
                  mv_code};
      end else if (mv_code[mvr_pkg::CODE_W-1]) begin
         delta = -$signed({1'b0, mag_delta});
      end else begin
         delta = $signed({1'b0, mag_delta});
      end
   end

   always_comb begin
      in_ready           = !q_full;
      q_push             = in_valid && !q_full;
      q_entry.clear      = (action == mvr_pkg::ACT_CLEAR);
      q_entry.idx        = {vector_sel, backward, vertical};
      q_entry.field_case = field_format && vertical && cfg.frame_picture;
      q_entry.rsize      = rsize;
      q_entry.delta      = delta;
   end

endmodule

FILE: rtl/mvr_queue.sv
// Short queue between the front and back stages.
module mvr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mvr_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output mvr_pkg::entry_type  head_entry
);

   mvr_pkg::entry_type               slot_ff [mvr_pkg::QUEUE_DEPTH];
   logic [mvr_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mvr_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mvr_pkg::QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      full       = (count_ff == mvr_pkg::QCNT_W'(mvr_pkg::QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_entry = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + mvr_pkg::QCNT_W'(push) - mvr_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/mvr_back.sv
// Back stage: predictor file, add and wrap, and the result register.
module mvr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  mvr_pkg::entry_type               head_entry,
   output logic                             pop,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [mvr_pkg::MV_W-1:0]  out_mv
);

   logic signed [mvr_pkg::PRED_W-1:0] pred_ff [mvr_pkg::NUM_PRED];
   logic signed [mvr_pkg::PRED_W-1:0] pred_in [mvr_pkg::NUM_PRED];
   logic                              out_valid_ff, out_valid_in;
   logic signed [mvr_pkg::MV_W-1:0]   out_mv_ff, out_mv_in;
   logic signed [mvr_pkg::PRED_W-1:0] pred_cur;
   logic signed [mvr_pkg::PRED_W-1:0] pred_use;
   logic signed [mvr_pkg::SUM_W-1:0]  sum;
   logic [mvr_pkg::RSIZE_W-1:0]       top_bit;
   logic signed [mvr_pkg::MV_W-1:0]   mv;

   always_comb begin
      pop      = head_valid && (!out_valid_ff || out_ready);
      pred_cur = pred_ff[head_entry.idx];
      pred_use = head_entry.field_case ?
                 {pred_cur[mvr_pkg::PRED_W-1], pred_cur[mvr_pkg::PRED_W-1:1]} : pred_cur;
      sum      = {{(mvr_pkg::SUM_W-mvr_pkg::PRED_W){pred_use[mvr_pkg::PRED_W-1]}}, pred_use}
               + {{(mvr_pkg::SUM_W-mvr_pkg::DELTA_W){head_entry.delta[mvr_pkg::DELTA_W-1]}},
                  head_entry.delta};
      top_bit  = head_entry.rsize + mvr_pkg::WRAP_BASE;
      for (int k = 0; k < mvr_pkg::MV_W; k++) begin
         mv[k] = (mvr_pkg::RSIZE_W'(k) <= top_bit) ? sum[k] : sum[top_bit];
      end

      pred_in      = pred_ff;
      out_valid_in = out_valid_ff;
      out_mv_in    = out_mv_ff;
      if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         out_valid_in = 1'b1;
         if (head_entry.clear) begin
            for (int i = 0; i < mvr_pkg::NUM_PRED; i++) begin
               pred_in[i] = '0;
            end
            out_mv_in = '0;
         end else begin
            pred_in[head_entry.idx] = head_entry.field_case ?
                                      {mv, 1'b0} : {mv[mvr_pkg::MV_W-1], mv};
            out_mv_in = mv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < mvr_pkg::NUM_PRED; i++) begin
            pred_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         pred_ff      <= pred_in;
      end
   end

   always_ff @(posedge clock) begin
      out_mv_ff <= out_mv_in;
   end

   assign out_valid = out_valid_ff;
   assign out_mv    = out_mv_ff;

   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      pop |=> out_valid_ff)
      else $error("popped request produced no result");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.clear) |=> (out_mv_ff == '0 && pred_ff[0] == '0
                                     && pred_ff[mvr_pkg::NUM_PRED-1] == '0))
      else $error("clear left a predictor or result nonzero");

   a_field_pred_even: assert property (@(posedge clock) disable iff (reset)
      (pop && !head_entry.clear && head_entry.field_case)
      |=> (pred_ff[$past(head_entry.idx)][0] == 1'b0))
      else $error("field predictor stored without doubling");

   a_recon_matches_pred: assert property (@(posedge clock) disable iff (reset)
      (pop && !head_entry.clear && !head_entry.field_case)
      |=> (pred_ff[$past(head_entry.idx)][mvr_pkg::MV_W-1:0] == out_mv_ff))
      else $error("stored predictor differs from result");

endmodule
